@@ sv/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] t_entry;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Broadcast to every cell each cycle.
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry value;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ sv/spq_cell.sv @@
`default_nettype none

module spq_cell (
    input  wire                 i_clk,
    input  spq_pkg::t_cell_ctl  i_ctl,
    input  wire                 i_valid,      // this slot holds an entry
    input  wire                 i_prev_keep,  // left neighbor stays put on insert
    input  spq_pkg::t_entry     i_prev_entry,
    input  spq_pkg::t_entry     i_next_entry,
    output spq_pkg::t_entry     o_entry,
    output logic                o_keep
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Held entry stays ahead of an equal newcomer.
    assign o_keep  = i_valid && (r_entry >= i_ctl.value);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && !o_keep) begin
            n_entry = i_prev_keep ? i_ctl.value : i_prev_entry;
        end else if (i_ctl.rem) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

@@ sv/sorted_priority_queue_top.sv @@
// Sorted priority queue, largest value first. Each slave transfer carries a
// command in tuser (0 insert, 1 remove) and a signed 32-bit value in tdata.
// Every command gives exactly one master transfer: removed value (largest
// entry, -1 on an empty remove, 0 on insert), status in tuser (0 ok, 1 remove
// from empty, 2 insert refused because full) and the occupancy afterwards.
// Equal values leave oldest first. The store is a row of DEPTH cells; on each
// command every cell compares its entry with the broadcast value and shifts
// left or right in the same cycle, so one command is taken per clock while the
// master side accepts results; its result appears in the cycle after it is taken,
// held in an output register while the master side stalls.
`default_nettype none

module sorted_priority_queue_top #(
    parameter int unsigned DEPTH = 16,
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1),
    localparam int unsigned OUT_DW = ((spq_pkg::VALUE_W + CNT_W + 7) / 8) * 8
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire  [31:0]        i_s_axis_tdata,   // [31:0] value
    input  wire  [0:0]         i_s_axis_tuser,   // [0] command
    output logic               o_m_axis_tvalid,
    input  wire                i_m_axis_tready,
    output logic [OUT_DW-1:0]  o_m_axis_tdata,   // [31:0] removed_value, then occupancy
    output logic [1:0]         o_m_axis_tuser    // [1:0] status
);
    import spq_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic             r_out_valid;
    t_entry           r_removed;
    t_status          r_status;
    logic [CNT_W-1:0] r_occ;
    logic [CNT_W-1:0] r_count;

    logic             n_out_valid;
    t_entry           n_removed;
    t_status          n_status;
    logic [CNT_W-1:0] n_count;

    t_cell_ctl        w_ctl;
    logic             w_fire;
    t_cmd             w_cmd;
    logic             w_empty;
    logic             w_full;
    t_entry           w_entry [DEPTH];
    logic [DEPTH-1:0] w_keep;
    logic [DEPTH-1:0] w_valid;

    assign w_cmd   = t_cmd'(i_s_axis_tuser[0]);
    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == FULL_CNT);

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_fire          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        w_ctl.ins   = 1'b0;
        w_ctl.rem   = 1'b0;
        w_ctl.value = t_entry'(i_s_axis_tdata);
        n_count     = r_count;
        n_removed   = '0;
        n_status    = ST_OK;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        if (w_fire) begin
            n_out_valid = 1'b1;
            case (w_cmd)
                CMD_INSERT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (w_empty) begin
                        n_status  = ST_EMPTY;
                        n_removed = '1;
                    end else begin
                        w_ctl.rem = 1'b1;
                        n_removed = w_entry[0];
                        n_count   = r_count - 1'b1;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_entry w_prev_entry;
        t_entry w_next_entry;
        logic   w_prev_keep;

        assign w_valid[i] = (CNT_W'(i) < r_count);

        if (i == 0) begin : g_head
            assign w_prev_entry = w_ctl.value;
            assign w_prev_keep  = 1'b1;
        end else begin : g_body
            assign w_prev_entry = w_entry[i-1];
            assign w_prev_keep  = w_keep[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign w_next_entry = w_entry[i];
        end else begin : g_mid
            assign w_next_entry = w_entry[i+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_valid      (w_valid[i]),
            .i_prev_keep  (w_prev_keep),
            .i_prev_entry (w_prev_entry),
            .i_next_entry (w_next_entry),
            .o_entry      (w_entry[i]),
            .o_keep       (w_keep[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
        if (w_fire) begin
            r_removed <= n_removed;
            r_status  <= n_status;
            r_occ     <= n_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DW'({r_occ, r_removed});
    assign o_m_axis_tuser  = r_status;

    // Held entries must stay in descending order.
    logic [DEPTH-2:0] w_order_err;
    for (genvar i = 0; i < DEPTH - 1; i++) begin : g_order
        assign w_order_err[i] = w_valid[i+1] && (w_entry[i] < w_entry[i+1]);
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("occupancy above depth");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_order_err == '0)
        else $error("entries out of order");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && (w_cmd == CMD_INSERT) && !w_full |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the queue");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == ST_EMPTY) |-> (r_removed == '1) && (r_occ == '0))
        else $error("bad empty-remove result");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == ST_FULL) |-> (r_occ == FULL_CNT) && (r_removed == '0))
        else $error("bad full-insert result");

endmodule

`default_nettype wire
